>>> sv/enveloped_tone_generator_defines.svh
// Assertion macros shared by the enveloped tone generator RTL.
`ifndef ENVELOPED_TONE_GENERATOR_DEFINES_SVH
`define ENVELOPED_TONE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that cons holds in the same cycle whenever ante holds.
`define ETG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("etg: assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define ETG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("etg: assertion failed");

`else

`define ETG_ASSERT_IMP(label, ante, cons)
`define ETG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/etg_pkg.sv
// Constants, types and the sine table builder of the enveloped tone generator.
`default_nettype none

package etg_pkg;

    // Audio format and tone shape.
    localparam int SAMPLE_RATE   = 44100;
    localparam int TONE_SAMPLES  = 5292;
    localparam int RAMP_SAMPLES  = 882;
    localparam int SINE_ENTRIES  = 1024;

    // Field and state widths.
    localparam int HZ_W      = 16;
    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = $clog2(SAMPLE_RATE);
    localparam int COUNT_W   = $clog2(TONE_SAMPLES + 1);
    localparam int RAMP_W    = $clog2(RAMP_SAMPLES + 1);
    localparam int IDX_W     = $clog2(SINE_ENTRIES);
    localparam int QUARTER   = SINE_ENTRIES / 4;
    localparam int QADDR_W   = $clog2(QUARTER + 1);
    localparam int MAG_W     = 14;
    localparam int ENV_FRAC  = 16;
    localparam int ENV_W     = ENV_FRAC + 1;

    // Item kinds.
    localparam logic KIND_PLAY = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Reciprocal for phase * SINE_ENTRIES / SAMPLE_RATE.
    localparam int          PHASE_RECIP_SHIFT = 24;
    localparam logic [63:0] PHASE_RECIP = (64'd1 << (PHASE_RECIP_SHIFT + IDX_W)) / SAMPLE_RATE;
    localparam int          PHASE_RECIP_W = $clog2(PHASE_RECIP + 64'd1);

    // Reciprocal for ramp_pos * 2^ENV_FRAC / RAMP_SAMPLES.
    localparam int          ENV_RECIP_SHIFT = 16;
    localparam logic [63:0] ENV_RECIP = (64'd1 << (ENV_RECIP_SHIFT + ENV_FRAC)) / RAMP_SAMPLES;
    localparam int          ENV_RECIP_W = $clog2(ENV_RECIP + 64'd1);

    // Queue between the front and the back.
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;
    localparam int QCNT_W      = QPTR_W + 1;

    // One tick's work as classified by the front.
    typedef struct packed {
        logic               silent;
        logic               full_env;
        logic [RAMP_W-1:0]  ramp_pos;
        logic [PHASE_W-1:0] phase;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Magnitudes of the first quadrant, entries 0 to QUARTER inclusive.
    typedef logic [MAG_W-1:0] t_sine_rom [0:QUARTER];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Sine of a first-quadrant angle, Q30 in and out, by a Taylor series.
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

    // Builds the quarter-wave table at elaboration.
    function automatic t_sine_rom sine_rom_build();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] mag;
        for (int j = 0; j <= QUARTER; j++) begin
            x      = (HALF_PI_Q30 * (64'(j) * 64'd4)) / SINE_ENTRIES;
            mag    = (sin_q30(x) * 64'd32767 + (64'd1 << 31)) >> 32;
            rom[j] = MAG_W'(mag);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

>>> sv/etg_front.sv
// Front part: accepts items, keeps tone state and classifies each tick.
`default_nettype none

`include "enveloped_tone_generator_defines.svh"

module etg_front
    import etg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_kind,
    input  wire logic [HZ_W-1:0]   i_tone_hz,
    output logic                   o_stall,
    output logic                   o_push,
    output t_work                  o_work,
    input  t_q_status              i_q_status
);

    localparam int SUM_W = $clog2(TONE_SAMPLES + RAMP_SAMPLES + 1);

    logic [HZ_W-1:0]    r_hz,    n_hz;
    logic [PHASE_W-1:0] r_step,  n_step;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PHASE_W-1:0] r_phase, n_phase;

    logic               accept;
    logic               silent;
    logic               ramp_up;
    logic               ramp_down;
    logic [PHASE_W:0]   phase_sum;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !o_stall;

    assign silent    = (r_hz == '0) || (r_count >= COUNT_W'(TONE_SAMPLES));
    assign ramp_up   = r_count < COUNT_W'(RAMP_SAMPLES);
    assign ramp_down = (SUM_W'(r_count) + SUM_W'(RAMP_SAMPLES)) > SUM_W'(TONE_SAMPLES);
    assign phase_sum = {1'b0, r_phase} + {1'b0, r_step};

    always_comb begin
        o_work.silent   = silent;
        o_work.full_env = !ramp_up && !ramp_down;
        o_work.ramp_pos = ramp_up ? RAMP_W'(r_count)
                                  : RAMP_W'(COUNT_W'(TONE_SAMPLES) - r_count);
        o_work.phase    = r_phase;
        o_push          = accept && (i_kind == KIND_TICK);
    end

    always_comb begin
        n_hz    = r_hz;
        n_step  = r_step;
        n_count = r_count;
        n_phase = r_phase;
        if (accept) begin
            if (i_kind == KIND_PLAY) begin
                n_hz    = i_tone_hz;
                n_step  = (i_tone_hz >= HZ_W'(SAMPLE_RATE))
                          ? PHASE_W'(i_tone_hz - HZ_W'(SAMPLE_RATE))
                          : PHASE_W'(i_tone_hz);
                n_count = '0;
                n_phase = '0;
            end else if (!silent) begin
                n_count = r_count + COUNT_W'(1);
                n_phase = (phase_sum >= (PHASE_W + 1)'(SAMPLE_RATE))
                          ? PHASE_W'(phase_sum - (PHASE_W + 1)'(SAMPLE_RATE))
                          : PHASE_W'(phase_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz    <= '0;
            r_step  <= '0;
            r_count <= COUNT_W'(TONE_SAMPLES);
            r_phase <= '0;
        end else begin
            r_hz    <= n_hz;
            r_step  <= n_step;
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    `ETG_ASSERT_NEXT(a_play_restarts, accept && (i_kind == KIND_PLAY), (r_count == '0) && (r_phase == '0))

endmodule

`default_nettype wire

>>> sv/etg_queue.sv
// Short queue of classified ticks between the front and the back.
`default_nettype none

`include "enveloped_tone_generator_defines.svh"

module etg_queue
    import etg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_work     i_work,
    input  wire logic i_pop,
    output t_work     o_work,
    output t_q_status o_status
);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_status.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_work         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    // The pointers wrap by their width, the depth being a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `ETG_ASSERT_IMP(a_no_push_when_full, i_push, !o_status.full)
    `ETG_ASSERT_IMP(a_no_pop_when_empty, i_pop, !o_status.empty)
    `ETG_ASSERT_IMP(a_count_in_range, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

>>> sv/etg_back.sv
// Back part: works out the sine index, the envelope and the sample of one tick.
`default_nettype none

`include "enveloped_tone_generator_defines.svh"

module etg_back
    import etg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  t_work                     i_work,
    input  t_q_status                 i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  wire logic                 i_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BACK = 2'd1;
    localparam logic [1:0] ST_ROM  = 2'd2;
    localparam logic [1:0] ST_MUL  = 2'd3;

    localparam int PPROD_W  = PHASE_W + PHASE_RECIP_W;
    localparam int PSCALE_W = PHASE_W + IDX_W;
    localparam int EPROD_W  = RAMP_W + ENV_RECIP_W;
    localparam int ESCALE_W = RAMP_W + ENV_FRAC;
    localparam int PROD_W   = MAG_W + ENV_W;

    localparam logic [ENV_W-1:0] ENV_UNITY = ENV_W'(1) << ENV_FRAC;
    localparam t_sine_rom        SINE_ROM  = sine_rom_build();

    logic [1:0]                r_state;
    logic                      r_silent;
    logic                      r_full_env;
    logic [RAMP_W-1:0]         r_ramp_pos;
    logic [PHASE_W-1:0]        r_phase;
    logic [IDX_W-1:0]          r_idx_est;
    logic [ENV_FRAC-1:0]       r_env_est;
    logic [PSCALE_W-1:0]       r_idx_back;
    logic [ESCALE_W-1:0]       r_env_back;
    logic [MAG_W-1:0]          r_rom_mag;
    logic                      r_neg;
    logic [ENV_W-1:0]          r_env;
    logic                      r_out_valid;
    logic [SAMPLE_W-1:0]       r_sample;

    logic [PPROD_W-1:0]        idx_prod;
    logic [EPROD_W-1:0]        env_prod;
    logic [PSCALE_W-1:0]       idx_rem;
    logic [ESCALE_W-1:0]       env_rem;
    logic [IDX_W-1:0]          idx_fix;
    logic [ENV_FRAC-1:0]       env_fix;
    logic [IDX_W-3:0]          idx_lo;
    logic [QADDR_W-1:0]        rom_addr;
    logic [PROD_W-1:0]         amp_prod;
    logic [MAG_W-1:0]          amp_mag;
    logic                      out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;
    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

    // Reciprocal estimates, low by at most one.
    assign idx_prod = PPROD_W'(i_work.phase) * PPROD_W'(PHASE_RECIP);
    assign env_prod = EPROD_W'(i_work.ramp_pos) * EPROD_W'(ENV_RECIP);

    // One correction step on each quotient.
    assign idx_rem = {r_phase, IDX_W'(0)} - r_idx_back;
    assign env_rem = {r_ramp_pos, ENV_FRAC'(0)} - r_env_back;
    assign idx_fix = (idx_rem >= PSCALE_W'(SAMPLE_RATE)) ? r_idx_est + IDX_W'(1) : r_idx_est;
    assign env_fix = (env_rem >= ESCALE_W'(RAMP_SAMPLES)) ? r_env_est + ENV_FRAC'(1) : r_env_est;

    // Quarter-wave folding: odd quadrants run backwards, the upper half is negative.
    assign idx_lo   = idx_fix[IDX_W-3:0];
    assign rom_addr = idx_fix[IDX_W-2] ? QADDR_W'(QUARTER) - QADDR_W'(idx_lo) : QADDR_W'(idx_lo);

    assign amp_prod = PROD_W'(r_rom_mag) * PROD_W'(r_env);
    assign amp_mag  = amp_prod[ENV_FRAC +: MAG_W];

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_silent   <= i_work.silent;
                r_full_env <= i_work.full_env;
                r_ramp_pos <= i_work.ramp_pos;
                r_phase    <= i_work.phase;
                r_idx_est  <= idx_prod[PHASE_RECIP_SHIFT +: IDX_W];
                r_env_est  <= env_prod[ENV_RECIP_SHIFT +: ENV_FRAC];
            end
            ST_BACK: begin
                r_idx_back <= PSCALE_W'(r_idx_est) * PSCALE_W'(SAMPLE_RATE);
                r_env_back <= ESCALE_W'(r_env_est) * ESCALE_W'(RAMP_SAMPLES);
            end
            ST_ROM: begin
                r_rom_mag <= SINE_ROM[rom_addr];
                r_neg     <= idx_fix[IDX_W-1];
                r_env     <= r_full_env ? ENV_UNITY : ENV_W'(env_fix);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_MUL) && out_free) begin
            if (r_silent) begin
                r_sample <= '0;
            end else if (r_neg) begin
                r_sample <= SAMPLE_W'(0) - SAMPLE_W'(amp_mag);
            end else begin
                r_sample <= SAMPLE_W'(amp_mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_state <= ST_BACK;
                    end
                end
                ST_BACK: begin
                    r_state <= ST_ROM;
                end
                ST_ROM: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if ((r_state == ST_MUL) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ETG_ASSERT_NEXT(a_silent_is_zero, (r_state == ST_MUL) && r_silent && out_free, o_sample == '0)

endmodule

`default_nettype wire

>>> sv/enveloped_tone_generator.sv
// Top level of the enveloped tone generator: front, queue and back joined.
//
//  Channel  Direction  Handshake          Payload
//  input    in         i_valid / o_stall  i_kind, i_tone_hz
//  output   out        o_valid / i_stall  o_sample
//
// The front takes a transaction each cycle while the two-entry queue has room; a play
// transaction only updates the tone state in the front and yields no output.
// The back steps each tick through reciprocal multiply, back multiply, correction and
// sine table read, envelope multiply, and takes no new tick until the last is done.
// Reset is synchronous and active low; afterwards the tone is over and ticks are silent.
// An output stall holds the sample in its register, the back waits and the queue fills.
`default_nettype none

module enveloped_tone_generator
    import etg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_kind,
    input  wire logic [HZ_W-1:0]       i_tone_hz,
    output logic                       o_stall,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  wire logic                  i_stall
);

    // Ticks classified by the front wait here until the back is free.
    logic      push;
    logic      pop;
    t_work     front_work;
    t_work     queue_work;
    t_q_status q_status;

    // The front keeps the frequency, the sample count and the exact phase.
    etg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .i_tone_hz  (i_tone_hz),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_work     (front_work),
        .i_q_status (q_status)
    );

    etg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (front_work),
        .i_pop    (pop),
        .o_work   (queue_work),
        .o_status (q_status)
    );

    // The back turns the phase and ramp position into one output sample.
    etg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_work     (queue_work),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_sample   (o_sample),
        .i_stall    (i_stall)
    );

endmodule

`default_nettype wire

>>> sim/enveloped_tone_generator_tb.sv
// Self-checking testbench of the enveloped tone generator, with a predictor of its samples.
module enveloped_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import etg_pkg::*;

    typedef longint unsigned t_u64;

    // One row of the directed script. Where pinned is set, the sample that the
    // tick must produce is typed into the row and is used instead of the
    // predicted one, so those rows do not lean on the predictor at all.
    typedef struct {
        logic                       kind;
        logic [HZ_W-1:0]            hz;
        logic                       pinned;
        logic signed [SAMPLE_W-1:0] literal;
    } t_script_row;

    localparam int SCRIPT_ROWS    = 25;
    localparam int RANDOM_ITEMS   = 1825;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       i_kind;
    logic [HZ_W-1:0]            i_tone_hz;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       i_stall;

    // Travel alongside the payload, so that the monitor knows at acceptance
    // whether this tick carries a typed-in sample.
    logic                       row_pinned;
    logic signed [SAMPLE_W-1:0] row_literal;

    // Predictor state: the tone being played, how many of its samples have
    // been produced, and where the phase stands, (hz * n) mod sample rate.
    logic [HZ_W-1:0]            tone_hz_now;
    logic [COUNT_W-1:0]         samples_played;
    logic [PHASE_W-1:0]         phase_acc;
    int                         sine_lut [0:SINE_ENTRIES-1];

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    int                         mismatches;
    logic                       steady_input;
    t_script_row                tone_script [0:SCRIPT_ROWS-1];

    enveloped_tone_generator DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_kind    (i_kind),
        .i_tone_hz (i_tone_hz),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_sample  (o_sample),
        .i_stall   (i_stall)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Sine of a first-quadrant angle in Q30, by a Taylor series up to the
    // fifteenth power, each product truncated to Q30.
    function automatic t_u64 sine_q30(input t_u64 x);
        t_u64   x2;
        t_u64   term;
        longint acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / t_u64'(2 * k * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return (acc < 0) ? t_u64'(0) : t_u64'(acc);
    endfunction

    // The full-wave table at a quarter of full scale, folded from the first
    // quadrant with the sign applied after rounding.
    initial begin
        int   m;
        int   q;
        logic neg;
        t_u64 x;
        t_u64 mag;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            m = 4 * k;
            if (m <= SINE_ENTRIES) begin
                q   = m;
                neg = 1'b0;
            end else if (m <= 2 * SINE_ENTRIES) begin
                q   = 2 * SINE_ENTRIES - m;
                neg = 1'b0;
            end else if (m <= 3 * SINE_ENTRIES) begin
                q   = m - 2 * SINE_ENTRIES;
                neg = 1'b1;
            end else begin
                q   = 4 * SINE_ENTRIES - m;
                neg = 1'b1;
            end
            x   = (HALF_PI_Q30 * t_u64'(q)) / SINE_ENTRIES;
            mag = (sine_q30(x) * 32767 + (t_u64'(1) << 31)) >> 32;
            sine_lut[k] = neg ? -int'(mag) : int'(mag);
        end
    end

    // Works out the sample of one tick and advances the tone state. A silent
    // tone, or one that has run its full length, yields zero and holds still.
    function automatic logic signed [SAMPLE_W-1:0] render_sample();
        t_u64        envelope;
        int unsigned lut_index;
        int unsigned magnitude;
        int unsigned stepped;
        int          entry;
        if (tone_hz_now == 0 || samples_played >= TONE_SAMPLES) begin
            return '0;
        end
        // Linear fade in, then flat, then linear fade out; the fade in wins
        // where the two ramps would overlap.
        if (samples_played < RAMP_SAMPLES) begin
            envelope = (t_u64'(samples_played) << ENV_FRAC) / RAMP_SAMPLES;
        end else if (samples_played + RAMP_SAMPLES > TONE_SAMPLES) begin
            envelope = (t_u64'(TONE_SAMPLES - samples_played) << ENV_FRAC) / RAMP_SAMPLES;
        end else begin
            envelope = t_u64'(1) << ENV_FRAC;
        end
        lut_index = (t_u64'(phase_acc) * SINE_ENTRIES) / SAMPLE_RATE;
        entry     = sine_lut[lut_index];
        magnitude = (entry < 0) ? -entry : entry;
        // Scaling is done on the magnitude, so the product truncates toward zero.
        magnitude = (t_u64'(magnitude) * envelope) >> ENV_FRAC;
        stepped   = phase_acc + tone_hz_now % SAMPLE_RATE;
        if (stepped >= SAMPLE_RATE) begin
            stepped = stepped - SAMPLE_RATE;
        end
        samples_played = samples_played + 1'b1;
        phase_acc      = PHASE_W'(stepped);
        return (entry < 0) ? -SAMPLE_W'(magnitude) : SAMPLE_W'(magnitude);
    endfunction

    // Idle cycles before a transaction: mostly none or a few, now and then a
    // long pause, and none at all while a steady stretch is running.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_input || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Tone frequencies: silence, aliased values at or above the sample rate,
    // very low tones and the ordinary audible range.
    function automatic logic [HZ_W-1:0] pick_tone_hz();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return HZ_W'($urandom_range(SAMPLE_RATE, 65535));
            end
            2: begin
                return HZ_W'($urandom_range(1, 20));
            end
            default: begin
                return HZ_W'($urandom_range(1, SAMPLE_RATE - 1));
            end
        endcase
    endfunction

    // Ticks after a play: mostly a short stretch of the fade in, some longer,
    // and a few that run past the end of the fade in onto the plateau.
    function automatic int pick_tick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 40);
        end else if (r < 95) begin
            return $urandom_range(41, 400);
        end
        return $urandom_range(860, 950);
    endfunction

    // Offers one transaction, starting at a falling edge, and returns at the
    // falling edge after it has been accepted. Valid stays high between
    // back-to-back transactions, so it is only ever assigned once per edge.
    task automatic send_item(input logic kind, input logic [HZ_W-1:0] hz,
                             input logic pinned, input logic signed [SAMPLE_W-1:0] literal);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_tone_hz   <= hz;
        row_pinned  <= pinned;
        row_literal <= literal;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    // The receiver stalls in bursts: free runs alternate with stalls, most of them short
    // and a few long, and now and then comes a long stretch with no stall.
    initial begin
        int free_run;
        int hold_run;
        int r;
        i_stall = 1'b0;
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                free_run = $urandom_range(50, 300);
                hold_run = 0;
            end else begin
                free_run = $urandom_range(1, 8);
                r        = $urandom_range(0, 99);
                if (r < 70) begin
                    hold_run = $urandom_range(1, 3);
                end else if (r < 95) begin
                    hold_run = $urandom_range(4, 10);
                end else begin
                    hold_run = $urandom_range(20, 60);
                end
            end
            repeat (free_run) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            repeat (hold_run) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
        end
    end

    // Monitor and scoreboard. An accepted play reloads the predictor; an
    // accepted tick queues the sample it must produce. Every accepted output
    // transaction is held against the oldest sample still waiting.
    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] predicted;
        logic signed [SAMPLE_W-1:0] wanted;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (i_kind == KIND_PLAY) begin
                    tone_hz_now    = i_tone_hz;
                    samples_played = '0;
                    phase_acc      = '0;
                end else begin
                    predicted = render_sample();
                    pending_samples.push_back(row_pinned ? row_literal : predicted);
                end
            end
            if (o_valid && !i_stall) begin
                if (pending_samples.size() == 0) begin
                    $error("sample: none expected, got %0d", o_sample);
                    mismatches++;
                end else begin
                    wanted = pending_samples.pop_front();
                    if (o_sample !== wanted) begin
                        $error("sample: expected %0d, got %0d", wanted, o_sample);
                        mismatches++;
                    end
                end
            end
        end
    end

    // The watchdog ends the run once too many cycles go by in which neither
    // channel completes a transaction.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("enveloped_tone_generator_tb failed");
        $finish;
    end

    initial begin
        int sent;
        int tick_count;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = KIND_PLAY;
        i_tone_hz      = '0;
        row_pinned     = 1'b0;
        row_literal    = '0;
        steady_input   = 1'b0;
        mismatches     = 0;
        tone_hz_now    = '0;
        samples_played = COUNT_W'(TONE_SAMPLES);
        phase_acc      = '0;

        // Directed script. After reset the tone is over, so ticks are silent;
        // a zero frequency is silent too; the first tick of any tone sits at
        // the bottom of the fade in and is zero; a tone at exactly the sample
        // rate never moves its phase off zero. The all-ones frequency checks
        // aliasing above the sample rate, and 1 Hz and 44099 Hz are the ends
        // of the audible range.
        tone_script = '{
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_TICK, 16'hFFFF,  1'b1, 16'sd0},
            '{KIND_PLAY, 16'd0,     1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_TICK, 16'd1234,  1'b1, 16'sd0},
            '{KIND_PLAY, 16'd1000,  1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b0, 16'sd0},
            '{KIND_TICK, 16'hFFFF,  1'b0, 16'sd0},
            '{KIND_PLAY, 16'hFFFF,  1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b0, 16'sd0},
            '{KIND_PLAY, 16'd44100, 1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_PLAY, 16'd44099, 1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b0, 16'sd0},
            '{KIND_PLAY, 16'd22050, 1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b0, 16'sd0},
            '{KIND_PLAY, 16'd1,     1'b0, 16'sd0},
            '{KIND_TICK, 16'd0,     1'b1, 16'sd0}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tone_script[r]) begin
            send_item(tone_script[r].kind, tone_script[r].hz,
                      tone_script[r].pinned, tone_script[r].literal);
        end

        // Random part: mostly a play followed by a run of ticks, the rest a
        // burst of loose transactions that cut tones short or tick over
        // silence. Tick transactions carry random frequency bits, which the
        // block must ignore. Runs are trimmed so the total stays on budget.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady_input = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                send_item(KIND_PLAY, pick_tone_hz(), 1'b0, '0);
                tick_count = pick_tick_count();
                if (tick_count > RANDOM_ITEMS - sent - 1) begin
                    tick_count = RANDOM_ITEMS - sent - 1;
                end
                repeat (tick_count) begin
                    send_item(KIND_TICK, HZ_W'($urandom_range(0, 65535)), 1'b0, '0);
                end
                sent += tick_count + 1;
            end else begin
                tick_count = $urandom_range(1, 10);
                if (tick_count > RANDOM_ITEMS - sent) begin
                    tick_count = RANDOM_ITEMS - sent;
                end
                repeat (tick_count) begin
                    send_item(logic'($urandom_range(0, 1)), pick_tone_hz(), 1'b0, '0);
                end
                sent += tick_count;
            end
        end
        steady_input = 1'b0;
        i_valid <= 1'b0;

        // Drain: the watchdog bounds this wait if samples go missing.
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("enveloped_tone_generator_tb passed");
        end else begin
            $display("enveloped_tone_generator_tb failed");
        end
        $finish;
    end

endmodule
